// File: hdl/ps2h_pkg.sv
// ---------------------------------------------------------------------------
// PS/2 host transceiver package
// Shared types, register map, command codes and reset values.
// ---------------------------------------------------------------------------
package ps2h_pkg;

  // Widths fixed by the register and payload fields
  localparam int unsigned CFG_W        = 20;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned CNT_W        = 4;

  // Default timer width
  localparam int unsigned TIMER_BITS_DEF = 20;

  // Register reset values
  localparam logic [CFG_W-1:0] INHIBIT_RST    = CFG_W'(300);
  localparam logic [CFG_W-1:0] REQ_SETUP_RST  = CFG_W'(10);
  localparam logic [CFG_W-1:0] TX_TIMEOUT_RST = CFG_W'(100000);
  localparam logic [CFG_W-1:0] RX_TIMEOUT_RST = CFG_W'(600000);

  // Bit counts that end the transmit and receive data phases
  localparam logic [CNT_W-1:0] TX_LAST_CNT = CNT_W'(8);
  localparam logic [CNT_W-1:0] RX_DATA_CNT = CNT_W'(8);
  localparam logic [CNT_W-1:0] RX_LAST_CNT = CNT_W'(10);

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_INHIBIT    = 2'd0,
    REG_REQ_SETUP  = 2'd1,
    REG_TX_TIMEOUT = 2'd2,
    REG_RX_TIMEOUT = 2'd3
  } reg_idx_e;

  // Commands carried with each tick
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_SEND = 2'd1,
    CMD_ARM  = 2'd2
  } cmd_e;

  // Configuration register bundle
  typedef struct packed {
    logic [CFG_W-1:0] inhibit_ticks;
    logic [CFG_W-1:0] request_setup_ticks;
    logic [CFG_W-1:0] tx_timeout_ticks;
    logic [CFG_W-1:0] rx_timeout_ticks;
  } cfg_t;

  // Result of one tick
  typedef struct packed {
    logic              clock_pull_low;
    logic              data_pull_low;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_done;
    logic              timeout;
    logic              busy_res;
  } res_t;

endpackage

// File: hdl/ps2h_core.sv
// ---------------------------------------------------------------------------
// PS/2 host transceiver core
// Transmit and receive sequencers, shift registers and timers, advanced by
// one line-sample tick whenever step_i is high.
// ---------------------------------------------------------------------------
module ps2h_core #(
  parameter int unsigned TIMER_BITS = ps2h_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ps2h_pkg::CMD_W-1:0]  command_i,
  input  logic [ps2h_pkg::BYTE_W-1:0] tx_byte_i,
  input  logic                        clock_line_i,
  input  logic                        data_line_i,
  input  ps2h_pkg::cfg_t              cfg_i,
  output ps2h_pkg::res_t              res_o
);
  import ps2h_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  typedef enum logic [9:0] {
    TX_IDLE     = 10'b00_0000_0001,
    TX_RELEASE  = 10'b00_0000_0010,
    TX_INHIBIT  = 10'b00_0000_0100,
    TX_REQUEST  = 10'b00_0000_1000,
    TX_WAITCLK  = 10'b00_0001_0000,
    TX_BITS     = 10'b00_0010_0000,
    TX_PARITY   = 10'b00_0100_0000,
    TX_ACKDATA  = 10'b00_1000_0000,
    TX_ACKCLK   = 10'b01_0000_0000,
    TX_RELWAIT  = 10'b10_0000_0000
  } tx_phase_e;

  typedef enum logic [2:0] {
    RX_WAIT     = 3'b001,
    RX_BITS     = 3'b010,
    RX_STOPHIGH = 3'b100
  } rx_phase_e;

  tx_phase_e             tx_phase_q, tx_phase_d;
  rx_phase_e             rx_phase_q, rx_phase_d;
  logic [BYTE_W-1:0]     tx_shift_q, tx_shift_d;
  logic                  tx_parity_q, tx_parity_d;
  logic [BYTE_W-1:0]     rx_shift_q, rx_shift_d;
  logic [CNT_W-1:0]      tx_cnt_q, tx_cnt_d;
  logic [CNT_W-1:0]      rx_cnt_q, rx_cnt_d;
  logic [TIMER_BITS-1:0] tx_timer_q, tx_timer_d;
  logic [TIMER_BITS-1:0] rx_timer_q, rx_timer_d;
  logic [TIMER_BITS-1:0] ph_timer_q, ph_timer_d;
  logic                  rx_armed_q, rx_armed_d;
  logic                  prev_clock_q;
  logic                  timeout_q, timeout_d;

  logic                  fall;
  logic                  tx_was_busy;
  logic                  rx_run;
  logic [TIMER_BITS-1:0] tx_timer_inc;
  logic [TIMER_BITS-1:0] rx_timer_inc;
  logic [TIMER_BITS-1:0] ph_timer_inc;
  logic [CFG_W-1:0]      ph_limit;
  logic                  ph_done;
  logic                  tx_expired;
  logic                  rx_expired;
  logic [CNT_W-1:0]      tx_cnt_inc;
  logic [CNT_W-1:0]      rx_cnt_inc;
  logic                  rx_valid;
  logic                  tx_done;
  logic                  cdrv;
  logic                  ddrv;

  // Saturating timer increments and limit compares
  assign tx_timer_inc = (tx_timer_q == TMAX) ? tx_timer_q : tx_timer_q + 1'b1;
  assign rx_timer_inc = (rx_timer_q == TMAX) ? rx_timer_q : rx_timer_q + 1'b1;
  assign ph_timer_inc = (ph_timer_q == TMAX) ? ph_timer_q : ph_timer_q + 1'b1;
  assign ph_limit     = (tx_phase_q == TX_REQUEST) ? cfg_i.request_setup_ticks
                                                   : cfg_i.inhibit_ticks;
  assign ph_done      = CMP_W'(ph_timer_inc) >= CMP_W'(ph_limit);
  assign tx_expired   = CMP_W'(tx_timer_inc) >= CMP_W'(cfg_i.tx_timeout_ticks);
  assign rx_expired   = CMP_W'(rx_timer_inc) >  CMP_W'(cfg_i.rx_timeout_ticks);
  assign tx_cnt_inc   = tx_cnt_q + 1'b1;
  assign rx_cnt_inc   = rx_cnt_q + 1'b1;

  assign fall        = prev_clock_q & ~clock_line_i;
  assign tx_was_busy = (tx_phase_q != TX_IDLE);
  assign rx_run      = ~tx_was_busy & (command_i != CMD_SEND);

  // Next state for one tick
  always_comb begin
    tx_phase_d  = tx_phase_q;
    rx_phase_d  = rx_phase_q;
    tx_shift_d  = tx_shift_q;
    tx_parity_d = tx_parity_q;
    rx_shift_d  = rx_shift_q;
    tx_cnt_d    = tx_cnt_q;
    rx_cnt_d    = rx_cnt_q;
    tx_timer_d  = tx_timer_q;
    rx_timer_d  = rx_timer_q;
    ph_timer_d  = ph_timer_q;
    rx_armed_d  = rx_armed_q;
    timeout_d   = timeout_q;
    rx_valid    = 1'b0;
    tx_done     = 1'b0;

    // Transmit sequencer
    if (!tx_was_busy) begin
      case (command_i)
        CMD_SEND: begin
          tx_phase_d  = TX_RELEASE;
          tx_shift_d  = tx_byte_i;
          tx_parity_d = 1'b1;
          tx_cnt_d    = '0;
          tx_timer_d  = '0;
          ph_timer_d  = '0;
          rx_phase_d  = RX_WAIT;
          rx_cnt_d    = '0;
          rx_armed_d  = 1'b0;
        end
        CMD_ARM: begin
          rx_armed_d = 1'b1;
          rx_timer_d = '0;
        end
        default: ;
      endcase
    end else begin
      tx_timer_d = tx_timer_inc;
      unique case (tx_phase_q)
        TX_RELEASE, TX_INHIBIT, TX_REQUEST: begin
          ph_timer_d = ph_done ? '0 : ph_timer_inc;
          if (ph_done) begin
            if (tx_phase_q == TX_RELEASE)      tx_phase_d = TX_INHIBIT;
            else if (tx_phase_q == TX_INHIBIT) tx_phase_d = TX_REQUEST;
            else                               tx_phase_d = TX_WAITCLK;
          end
        end
        TX_WAITCLK: begin
          if (!clock_line_i) begin
            tx_phase_d = TX_BITS;
            tx_cnt_d   = '0;
          end else if (tx_expired) begin
            tx_phase_d = TX_IDLE;
            timeout_d  = 1'b1;
          end
        end
        TX_BITS: begin
          if (fall) begin
            tx_parity_d = tx_parity_q ^ tx_shift_q[0];
            tx_shift_d  = tx_shift_q >> 1;
            tx_cnt_d    = tx_cnt_inc;
            if (tx_cnt_inc >= TX_LAST_CNT) tx_phase_d = TX_PARITY;
          end
        end
        TX_PARITY: begin
          if (fall) tx_phase_d = TX_ACKDATA;
        end
        TX_ACKDATA: begin
          if (!data_line_i) tx_phase_d = TX_ACKCLK;
        end
        TX_ACKCLK: begin
          if (!clock_line_i) tx_phase_d = TX_RELWAIT;
        end
        TX_RELWAIT: begin
          if (clock_line_i || data_line_i) begin
            tx_phase_d = TX_IDLE;
            tx_done    = 1'b1;
            timeout_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Receive sequencer, held while a transmit runs
    if (rx_run) begin
      unique case (rx_phase_q)
        RX_WAIT: begin
          if (!clock_line_i) begin
            rx_phase_d = RX_BITS;
            rx_cnt_d   = '0;
            rx_armed_d = 1'b0;
          end else if (rx_armed_d) begin
            rx_timer_d = (command_i == CMD_ARM) ? TIMER_BITS'(1) : rx_timer_inc;
            if ((command_i == CMD_ARM) ? (CFG_W'(0) == cfg_i.rx_timeout_ticks)
                                       : rx_expired) begin
              timeout_d  = 1'b1;
              rx_armed_d = 1'b0;
            end
          end
        end
        RX_BITS: begin
          if (fall) begin
            if (rx_cnt_q < RX_DATA_CNT) rx_shift_d[rx_cnt_q[2:0]] = data_line_i;
            rx_cnt_d = rx_cnt_inc;
            if (rx_cnt_inc >= RX_LAST_CNT) rx_phase_d = RX_STOPHIGH;
          end
        end
        RX_STOPHIGH: begin
          if (clock_line_i) begin
            rx_phase_d = RX_WAIT;
            rx_valid   = 1'b1;
            timeout_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Line drives follow the state after this tick
    cdrv = 1'b0;
    ddrv = 1'b0;
    unique case (tx_phase_d)
      TX_INHIBIT: cdrv = 1'b1;
      TX_REQUEST: begin
        cdrv = 1'b1;
        ddrv = 1'b1;
      end
      TX_WAITCLK: ddrv = 1'b1;
      TX_BITS:    ddrv = ~tx_shift_d[0];
      TX_PARITY:  ddrv = ~tx_parity_d;
      default: ;
    endcase
  end

  // Result of this tick
  assign res_o.clock_pull_low = cdrv;
  assign res_o.data_pull_low  = ddrv;
  assign res_o.rx_valid       = rx_valid;
  assign res_o.rx_byte        = rx_valid ? rx_shift_d : '0;
  assign res_o.tx_done        = tx_done;
  assign res_o.timeout        = timeout_d;
  assign res_o.busy_res       = (tx_phase_d != TX_IDLE);

  // Hold state between ticks, advance on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_phase_q   <= TX_IDLE;
      rx_phase_q   <= RX_WAIT;
      tx_shift_q   <= '0;
      tx_parity_q  <= 1'b1;
      rx_shift_q   <= '0;
      tx_cnt_q     <= '0;
      rx_cnt_q     <= '0;
      tx_timer_q   <= '0;
      rx_timer_q   <= '0;
      ph_timer_q   <= '0;
      rx_armed_q   <= 1'b0;
      prev_clock_q <= 1'b1;
      timeout_q    <= 1'b0;
    end else if (step_i) begin
      tx_phase_q   <= tx_phase_d;
      rx_phase_q   <= rx_phase_d;
      tx_shift_q   <= tx_shift_d;
      tx_parity_q  <= tx_parity_d;
      rx_shift_q   <= rx_shift_d;
      tx_cnt_q     <= tx_cnt_d;
      rx_cnt_q     <= rx_cnt_d;
      tx_timer_q   <= tx_timer_d;
      rx_timer_q   <= rx_timer_d;
      ph_timer_q   <= ph_timer_d;
      rx_armed_q   <= rx_armed_d;
      prev_clock_q <= clock_line_i;
      timeout_q    <= timeout_d;
    end
  end

endmodule

// File: hdl/ps2_host_line_transceiver.sv
// ---------------------------------------------------------------------------
// PS/2 host line transceiver
// Host side of a PS/2 link, advanced one line-sample tick per transaction.
// ---------------------------------------------------------------------------
//  Channel  Handshake                  Payload
//  input    in_valid_i / in_stall_o    command_i, tx_byte_i, clock_line_i,
//                                      data_line_i
//  output   out_valid_o / out_stall_i  clock_pull_low_o, data_pull_low_o,
//                                      rx_valid_o, rx_byte_o, tx_done_o,
//                                      timeout_o, busy_res_o
//  config   APB (psel .. pready)       four 20-bit timing registers
//
//  One tick is taken per clock cycle unless stalled; its result enters
//  the output register on the next cycle. The tick logic is a single
//  pass from the sequencer state and the inputs to the result register.
//  Reset clears both sequencers and loads the default register values.
//  A held result stalls the input only while out_stall_i is high.
// ---------------------------------------------------------------------------
module ps2_host_line_transceiver #(
  parameter int unsigned TIMER_BITS = ps2h_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Tick input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ps2h_pkg::CMD_W-1:0]      command_i,
  input  logic [ps2h_pkg::BYTE_W-1:0]     tx_byte_i,
  input  logic                            clock_line_i,
  input  logic                            data_line_i,
  // Tick result
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            clock_pull_low_o,
  output logic                            data_pull_low_o,
  output logic                            rx_valid_o,
  output logic [ps2h_pkg::BYTE_W-1:0]     rx_byte_o,
  output logic                            tx_done_o,
  output logic                            timeout_o,
  output logic                            busy_res_o,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ps2h_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ps2h_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ps2h_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ps2h_pkg::*;

  cfg_t     cfg_q;
  res_t     res;
  res_t     res_q;
  logic     out_valid_q;
  logic     accept;
  logic     cfg_wr;
  reg_idx_e reg_idx;

  // Register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inhibit_ticks       <= INHIBIT_RST;
      cfg_q.request_setup_ticks <= REQ_SETUP_RST;
      cfg_q.tx_timeout_ticks    <= TX_TIMEOUT_RST;
      cfg_q.rx_timeout_ticks    <= RX_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INHIBIT:    cfg_q.inhibit_ticks       <= pwdata[CFG_W-1:0];
        REG_REQ_SETUP:  cfg_q.request_setup_ticks <= pwdata[CFG_W-1:0];
        REG_TX_TIMEOUT: cfg_q.tx_timeout_ticks    <= pwdata[CFG_W-1:0];
        REG_RX_TIMEOUT: cfg_q.rx_timeout_ticks    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INHIBIT:    prdata = APB_DATA_W'(cfg_q.inhibit_ticks);
      REG_REQ_SETUP:  prdata = APB_DATA_W'(cfg_q.request_setup_ticks);
      REG_TX_TIMEOUT: prdata = APB_DATA_W'(cfg_q.tx_timeout_ticks);
      REG_RX_TIMEOUT: prdata = APB_DATA_W'(cfg_q.rx_timeout_ticks);
      default:        prdata = '0;
    endcase
  end

  // Take a tick whenever the result register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  ps2h_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .command_i    (command_i),
    .tx_byte_i    (tx_byte_i),
    .clock_line_i (clock_line_i),
    .data_line_i  (data_line_i),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign clock_pull_low_o = res_q.clock_pull_low;
  assign data_pull_low_o  = res_q.data_pull_low;
  assign rx_valid_o       = res_q.rx_valid;
  assign rx_byte_o        = res_q.rx_byte;
  assign tx_done_o        = res_q.tx_done;
  assign timeout_o        = res_q.timeout;
  assign busy_res_o       = res_q.busy_res;

endmodule

// File: hdl/ps2h_checker.sv
// ---------------------------------------------------------------------------
// PS/2 host transceiver checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module ps2h_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            clock_pull_low_o,
  input logic                            data_pull_low_o,
  input logic                            rx_valid_o,
  input logic [ps2h_pkg::BYTE_W-1:0]     rx_byte_o,
  input logic                            tx_done_o,
  input logic                            timeout_o,
  input logic                            busy_res_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rx_byte_o)
      && $stable(busy_res_o) && $stable(timeout_o))
    else $error("stalled result changed");

  // A finished transmit leaves the block idle with the timeout cleared
  a_tx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_done_o |-> !busy_res_o && !timeout_o && !rx_valid_o)
    else $error("transmit done while busy or timed out");

  // A received byte never coincides with a transmit
  a_rx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> !busy_res_o && !timeout_o)
    else $error("receive completed during transmit");

  // Drop the byte when nothing was received
  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rx_valid_o |-> rx_byte_o == '0)
    else $error("receive byte not cleared");

  // Clock inhibit or any other line pull only inside a transmit
  a_inhibit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (clock_pull_low_o || data_pull_low_o) |-> busy_res_o)
    else $error("line driven while idle");

endmodule

bind ps2_host_line_transceiver ps2h_checker u_ps2h_checker (.*);
